// ===== rtl/core/t2g_pkg.sv =====
// Shared types and codes for the transcript-to-genome mapper.
package t2g_pkg;

  // Command codes on the input channel
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_MAP   = 2'd2;
  localparam logic [1:0] CMD_JUNC  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_ADD  = 2'd0;
  localparam logic [1:0] KIND_MAP  = 2'd1;
  localparam logic [1:0] KIND_JUNC = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_BEYOND  = 3'd2;
  localparam logic [2:0] ST_NONEXON = 3'd3;
  localparam logic [2:0] ST_NOJUNC  = 3'd4;

  // Operation as classified by the front end
  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_ADD,
    OP_SKIP,
    OP_MAP,
    OP_JUNC
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] fstart;
    logic [31:0] fend;
    logic [31:0] qpos;
    logic [15:0] span;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [31:0] gpos;
    logic [31:0] jpos;
    logic [31:0] ilen;
    logic        last;
  } result_t;

endpackage

// ===== rtl/core/transcript_to_genome_mapper_unit.sv =====
// Transcript-to-genome mapper top level: command queue front end and table back end.
// Add answers directly from idle on an empty or full table or a non-exon; otherwise the sorted
// insert walks from the tail. Map walks from the head; a junction query walks the exon pairs
// and gives its junction list, the last entry marked; clear gives no result.
// The back end takes one command at a time and takes no new one until its walk over the exon
// table memory is done, plus any output stall.
// Reset (synchronous, rst_n low) empties the table and queues; table contents are not cleared.
module transcript_to_genome_mapper_unit #(
  parameter int MAX_EXONS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic        in_is_exon,
  input  logic [31:0] in_feature_start,
  input  logic [31:0] in_feature_end,
  input  logic [31:0] in_query_position,
  input  logic [15:0] in_read_span,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_status,
  output logic [31:0] out_genomic_position,
  output logic [31:0] out_junction_position,
  output logic [31:0] out_intron_length,
  output logic        out_last
);
  import t2g_pkg::*;

  item_t   q_item;
  logic    q_valid;
  logic    q_pop;
  result_t res;

  t2g_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_is_exon        (in_is_exon),
    .in_feature_start  (in_feature_start),
    .in_feature_end    (in_feature_end),
    .in_query_position (in_query_position),
    .in_read_span      (in_read_span),
    .q_valid           (q_valid),
    .q_pop             (q_pop),
    .q_item            (q_item)
  );

  t2g_exec #(.MAX_EXONS(MAX_EXONS)) u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (res)
  );

  // Result fields
  assign out_kind              = res.kind;
  assign out_status            = res.status;
  assign out_genomic_position  = res.gpos;
  assign out_junction_position = res.jpos;
  assign out_intron_length     = res.ilen;
  assign out_last              = res.last;

endmodule

// ===== rtl/core/t2g_front.sv =====
// Front end: accepts commands, classifies them and queues them for the back end.
module t2g_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      in_cmd,
  input  logic            in_is_exon,
  input  logic [31:0]     in_feature_start,
  input  logic [31:0]     in_feature_end,
  input  logic [31:0]     in_query_position,
  input  logic [15:0]     in_read_span,
  output logic            q_valid,
  input  logic            q_pop,
  output t2g_pkg::item_t  q_item
);
  import t2g_pkg::*;

  item_t       fifo_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        push;
  logic        pop;
  item_t       cls;

  // Classify the incoming command
  always_comb begin
    cls.fstart = in_feature_start;
    cls.fend   = in_feature_end;
    cls.qpos   = in_query_position;
    cls.span   = in_read_span;
    unique case (in_cmd)
      CMD_CLEAR: cls.op = OP_CLEAR;
      CMD_ADD:   cls.op = in_is_exon ? OP_ADD : OP_SKIP;
      CMD_MAP:   cls.op = OP_MAP;
      default:   cls.op = OP_JUNC;
    endcase
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = fifo_r[rd_ptr_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= cls;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers out of step");

endmodule

// ===== rtl/core/t2g_exec.sv =====
// Back end: exon table memory, insert/map/junction walks and output register.
module t2g_exec #(
  parameter int MAX_EXONS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_pop,
  input  t2g_pkg::item_t    q_item,
  output logic              out_valid,
  input  logic              out_stall,
  output t2g_pkg::result_t  out_res
);
  import t2g_pkg::*;

  localparam int AW = (MAX_EXONS > 1) ? $clog2(MAX_EXONS) : 1;
  localparam int CW = $clog2(MAX_EXONS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_PUT,
    S_MAP,
    S_JUN,
    S_JDONE
  } state_t;

  // Exon table: {start, end} per entry
  logic [63:0] mem [MAX_EXONS];
  logic [63:0] rdata_r;

  state_t      state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [31:0] key_r, key_nxt;
  logic [31:0] kend_r, kend_nxt;
  logic [31:0] p_r, p_nxt;
  logic [15:0] span_r, span_nxt;
  logic [31:0] cur_end_r, cur_end_nxt;
  logic [31:0] prev_end_r, prev_end_nxt;
  logic [31:0] prev_len_r, prev_len_nxt;
  logic        pend_v_r, pend_v_nxt;
  logic [31:0] pend_jpos_r, pend_jpos_nxt;
  logic [31:0] pend_ilen_r, pend_ilen_nxt;
  logic        out_valid_r;
  result_t     out_res_r;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [63:0]   wr_data;
  logic          emit;
  result_t       emit_res;
  logic          slot_free;
  logic [31:0]   d_start, d_end, d_len;
  logic [31:0]   ce, rem;
  logic          is_tail;

  assign slot_free = !out_valid_r || !out_stall;
  assign d_start   = rdata_r[63:32];
  assign d_end     = rdata_r[31:0];
  assign d_len     = d_end - d_start + 32'd1;
  assign ce        = cur_end_r + prev_len_r;
  assign rem       = ce - p_r + 32'd1;
  assign is_tail   = (CW'(idx_r) == count_r - CW'(1));

  // Command sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    key_nxt       = key_r;
    kend_nxt      = kend_r;
    p_nxt         = p_r;
    span_nxt      = span_r;
    cur_end_nxt   = cur_end_r;
    prev_end_nxt  = prev_end_r;
    prev_len_nxt  = prev_len_r;
    pend_v_nxt    = pend_v_r;
    pend_jpos_nxt = pend_jpos_r;
    pend_ilen_nxt = pend_ilen_r;
    q_pop    = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = '0;
    emit     = 1'b0;
    emit_res = '0;
    emit_res.last = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          unique case (q_item.op)
            OP_CLEAR: count_nxt = '0;
            OP_SKIP: begin
              emit = 1'b1;
              emit_res.kind   = KIND_ADD;
              emit_res.status = ST_NONEXON;
            end
            OP_ADD: begin
              key_nxt  = q_item.fstart;
              kend_nxt = q_item.fend;
              if (count_r >= CW'(MAX_EXONS)) begin
                emit = 1'b1;
                emit_res.kind   = KIND_ADD;
                emit_res.status = ST_FULL;
              end else if (count_r == '0) begin
                wr_en     = 1'b1;
                wr_addr   = '0;
                wr_data   = {q_item.fstart, q_item.fend};
                count_nxt = count_r + CW'(1);
                emit = 1'b1;
                emit_res.kind   = KIND_ADD;
                emit_res.status = ST_OK;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = AW'(count_r - CW'(1));
                idx_nxt   = AW'(count_r - CW'(1));
                state_nxt = S_INS;
              end
            end
            OP_MAP: begin
              p_nxt = q_item.qpos;
              if (count_r == '0) begin
                emit = 1'b1;
                emit_res.kind   = KIND_MAP;
                emit_res.status = ST_BEYOND;
              end else begin
                rd_en     = 1'b1;
                idx_nxt   = '0;
                state_nxt = S_MAP;
              end
            end
            default: begin
              p_nxt       = q_item.qpos;
              span_nxt    = q_item.span;
              cur_end_nxt = '0;
              pend_v_nxt  = 1'b0;
              idx_nxt     = '0;
              if (count_r < CW'(2)) begin
                state_nxt = S_JDONE;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_JUN;
              end
            end
          endcase
        end
      end

      // Walk down from the tail, shifting larger starts up one slot
      S_INS: begin
        if (slot_free) begin
          if (d_start > key_r) begin
            wr_en   = 1'b1;
            wr_addr = idx_r + AW'(1);
            wr_data = rdata_r;
            if (idx_r == '0) begin
              state_nxt = S_INS_PUT;
            end else begin
              rd_en   = 1'b1;
              rd_addr = idx_r - AW'(1);
              idx_nxt = idx_r - AW'(1);
            end
          end else begin
            wr_en     = 1'b1;
            wr_addr   = idx_r + AW'(1);
            wr_data   = {key_r, kend_r};
            count_nxt = count_r + CW'(1);
            emit = 1'b1;
            emit_res.kind   = KIND_ADD;
            emit_res.status = ST_OK;
            state_nxt = S_IDLE;
          end
        end
      end

      S_INS_PUT: begin
        if (slot_free) begin
          wr_en     = 1'b1;
          wr_addr   = '0;
          wr_data   = {key_r, kend_r};
          count_nxt = count_r + CW'(1);
          emit = 1'b1;
          emit_res.kind   = KIND_ADD;
          emit_res.status = ST_OK;
          state_nxt = S_IDLE;
        end
      end

      // Subtract exon lengths until the position falls inside one
      S_MAP: begin
        if (slot_free) begin
          if (p_r > d_len) begin
            p_nxt = p_r - d_len;
            if (is_tail) begin
              emit = 1'b1;
              emit_res.kind   = KIND_MAP;
              emit_res.status = ST_BEYOND;
              state_nxt = S_IDLE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = idx_r + AW'(1);
              idx_nxt = idx_r + AW'(1);
            end
          end else begin
            emit = 1'b1;
            emit_res.kind   = KIND_MAP;
            emit_res.status = ST_OK;
            emit_res.gpos   = d_start + p_r - 32'd1;
            state_nxt = S_IDLE;
          end
        end
      end

      // Pair walk; one junction is held back so the final one carries last
      S_JUN: begin
        if (slot_free) begin
          prev_end_nxt = d_end;
          prev_len_nxt = d_len;
          if (idx_r == '0) begin
            rd_en   = 1'b1;
            rd_addr = AW'(1);
            idx_nxt = AW'(1);
          end else begin
            cur_end_nxt = ce;
            if (p_r <= ce && rem >= {16'd0, span_r}) begin
              state_nxt = S_JDONE;
            end else begin
              if (p_r <= ce) begin
                if (pend_v_r) begin
                  emit = 1'b1;
                  emit_res.kind   = KIND_JUNC;
                  emit_res.status = ST_OK;
                  emit_res.jpos   = pend_jpos_r;
                  emit_res.ilen   = pend_ilen_r;
                  emit_res.last   = 1'b0;
                end
                pend_v_nxt    = 1'b1;
                pend_jpos_nxt = ce + 32'd1;
                pend_ilen_nxt = d_start - prev_end_r - 32'd1;
                span_nxt      = span_r - rem[15:0];
                p_nxt         = ce + 32'd1;
              end
              if (is_tail) begin
                state_nxt = S_JDONE;
              end else begin
                rd_en   = 1'b1;
                rd_addr = idx_r + AW'(1);
                idx_nxt = idx_r + AW'(1);
              end
            end
          end
        end
      end

      S_JDONE: begin
        if (slot_free) begin
          emit = 1'b1;
          emit_res.kind = KIND_JUNC;
          if (pend_v_r) begin
            emit_res.status = ST_OK;
            emit_res.jpos   = pend_jpos_r;
            emit_res.ilen   = pend_ilen_r;
          end else begin
            emit_res.status = ST_NOJUNC;
          end
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Table memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  // State, working registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      pend_v_r <= pend_v_nxt;
      if (slot_free) out_valid_r <= emit;
    end
    idx_r       <= idx_nxt;
    key_r       <= key_nxt;
    kend_r      <= kend_nxt;
    p_r         <= p_nxt;
    span_r      <= span_nxt;
    cur_end_r   <= cur_end_nxt;
    prev_end_r  <= prev_end_nxt;
    prev_len_r  <= prev_len_nxt;
    pend_jpos_r <= pend_jpos_nxt;
    pend_ilen_r <= pend_ilen_nxt;
    if (emit) out_res_r <= emit_res;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_EXONS)) else $error("exon count overflow");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE) else $error("pop while busy");
  a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> wr_addr != rd_addr) else $error("read/write collision");
  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> slot_free) else $error("result dropped");

endmodule

// ===== verif/transcript_to_genome_mapper_unit_tb.sv =====
// Self-checking testbench for the transcript-to-genome mapper unit.
`timescale 1ns / 100ps

module transcript_to_genome_mapper_unit_tb;
  import t2g_pkg::*;

  localparam int MAXE = 64;
  localparam int CYCLE_LIMIT = 10000000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        is_exon;
    logic [31:0] fstart;
    logic [31:0] fend;
    logic [31:0] qpos;
    logic [15:0] span;
  } cmd_item_t;

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [1:0] in_cmd;
  logic in_is_exon;
  logic [31:0] in_feature_start, in_feature_end, in_query_position;
  logic [15:0] in_read_span;
  logic out_valid, out_stall;
  logic [1:0] out_kind;
  logic [2:0] out_status;
  logic [31:0] out_genomic_position, out_junction_position, out_intron_length;
  logic out_last;

  transcript_to_genome_mapper_unit #(.MAX_EXONS(MAXE)) dut (.*);

  // Shadow copy of the exon table
  logic [31:0] sh_start [MAXE];
  logic [31:0] sh_end [MAXE];
  int unsigned sh_count;
  int unsigned pending_count;

  cmd_item_t cmd_q[$];
  result_t   expected_q[$];
  int errors, cycles;

  // Compute the results a command causes and update the shadow table
  task automatic predict_command(input cmd_item_t c);
    result_t r;
    logic [31:0] p, len, cur_end, rem, sp;
    int pos, k;
    r = '0;
    r.last = 1'b1;
    case (c.cmd)
      CMD_CLEAR: sh_count = 0;
      CMD_ADD: begin
        r.kind = KIND_ADD;
        if (!c.is_exon) r.status = ST_NONEXON;
        else if (sh_count >= MAXE) r.status = ST_FULL;
        else begin
          pos = sh_count;
          while (pos > 0 && sh_start[pos-1] > c.fstart) pos--;
          for (int j = sh_count; j > pos; j--) begin
            sh_start[j] = sh_start[j-1];
            sh_end[j] = sh_end[j-1];
          end
          sh_start[pos] = c.fstart;
          sh_end[pos] = c.fend;
          sh_count++;
          r.status = ST_OK;
        end
        expected_q.insert(expected_q.size(), r);
      end
      CMD_MAP: begin
        r.kind = KIND_MAP;
        r.status = ST_BEYOND;
        p = c.qpos;
        for (int i = 0; i < sh_count; i++) begin
          len = sh_end[i] - sh_start[i] + 32'd1;
          if (p > len) p = p - len;
          else begin
            r.status = ST_OK;
            r.gpos = sh_start[i] + p - 32'd1;
            break;
          end
        end
        expected_q.insert(expected_q.size(), r);
      end
      default: begin
        k = 0;
        cur_end = 0;
        p = c.qpos;
        sp = {16'd0, c.span};
        for (int i = 0; i + 1 < sh_count; i++) begin
          cur_end = cur_end + (sh_end[i] - sh_start[i] + 32'd1);
          if (p <= cur_end) begin
            rem = cur_end - p + 32'd1;
            if (rem >= sp) break;
            r = '0;
            r.kind = KIND_JUNC;
            r.status = ST_OK;
            r.jpos = cur_end + 32'd1;
            r.ilen = sh_start[i+1] - sh_end[i] - 32'd1;
            expected_q.insert(expected_q.size(), r);
            k++;
            sp = sp - rem;
            p = cur_end + 32'd1;
          end
        end
        if (k == 0) begin
          r = '0;
          r.kind = KIND_JUNC;
          r.status = ST_NOJUNC;
          r.last = 1'b1;
          expected_q.insert(expected_q.size(), r);
        end else expected_q[$].last = 1'b1;
      end
    endcase
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Builds one command item from its fields
  function automatic cmd_item_t mk(input logic [1:0] cm, input logic ex,
      input logic [31:0] fs, input logic [31:0] fe, input logic [31:0] q,
      input logic [15:0] s);
    mk = '{cm, ex, fs, fe, q, s};
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver
  int in_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        predict_command({in_cmd, in_is_exon, in_feature_start, in_feature_end,
                         in_query_position, in_read_span});
        pending_count--;
      end
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        cmd_item_t c;
        c = cmd_q.pop_front();
        in_valid <= 1'b1;
        {in_cmd, in_is_exon, in_feature_start, in_feature_end,
         in_query_position, in_read_span} <= c;
        in_gap = gap_len();
      end else in_valid <= 1'b0;
    end
  end

  // Monitor and receiver stall
  int out_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result kind=%0d status=%0d",
                                     out_kind, out_status);
        end else begin
          result_t e;
          e = expected_q.pop_front();
          if (e !== {out_kind, out_status, out_genomic_position,
                     out_junction_position, out_intron_length, out_last}) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch exp k=%0d s=%0d g=%0h j=%0h i=%0h l=%0b",
                        " got k=%0d s=%0d g=%0h j=%0h i=%0h l=%0b"},
                e.kind, e.status, e.gpos, e.jpos, e.ilen, e.last, out_kind, out_status,
                out_genomic_position, out_junction_position, out_intron_length, out_last);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        out_gap = gap_len();
      end
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push(input cmd_item_t c);
    cmd_q.insert(cmd_q.size(), c);
    pending_count++;
  endtask

  // Build a transcript of n exons with random gaps, then query it
  task automatic random_transcript();
    int n;
    logic [31:0] base, len;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 66) : $urandom_range(1, 8);
    push(mk(CMD_CLEAR, 1'($urandom), $urandom, $urandom, $urandom, 16'($urandom)));
    base = $urandom_range(1, 1000000);
    for (int i = 0; i < n; i++) begin
      len = $urandom_range(1, 200);
      if ($urandom_range(0, 7) == 0)
        push(mk(CMD_ADD, 1'b0, $urandom, $urandom, $urandom, 16'($urandom)));
      push(mk(CMD_ADD, 1'b1, base, base + len - 1, $urandom, 16'($urandom)));
      base = base + len + $urandom_range(0, 5000);
    end
    for (int i = 0; i < $urandom_range(2, 6); i++) begin
      if ($urandom_range(0, 1))
        push(mk(CMD_MAP, 1'($urandom), $urandom, $urandom,
                $urandom_range(0, n * 220), 16'($urandom)));
      else
        push(mk(CMD_JUNC, 1'($urandom), $urandom, $urandom,
                $urandom_range(0, n * 150), 16'($urandom_range(0, 600))));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = '0; in_is_exon = 1'b0;
    in_feature_start = '0; in_feature_end = '0;
    in_query_position = '0; in_read_span = '0;
    out_stall = 1'b0;
    sh_count = 0; pending_count = 0;
    errors = 0; cycles = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table queries, extremes, unsorted and equal starts, wrap
    push(mk(CMD_MAP, 1'b1, '1, '1, 32'd1, 16'd0));
    push(mk(CMD_JUNC, 1'b0, 0, 0, 32'd1, 16'hFFFF));
    push(mk(CMD_ADD, 1'b0, '1, '1, '1, '1));
    push(mk(CMD_ADD, 1'b1, 32'd500, 32'd599, 0, 0));
    push(mk(CMD_JUNC, 1'b1, 0, 0, 32'd1, 16'd200));
    push(mk(CMD_ADD, 1'b1, 32'd100, 32'd149, 0, 0));
    push(mk(CMD_ADD, 1'b1, 32'd500, 32'd509, 0, 0));
    push(mk(CMD_ADD, 1'b1, 32'hFFFF_FF00, 32'hFFFF_FFFF, 0, 0));
    push(mk(CMD_MAP, 1'b0, 0, 0, 32'd0, 0));
    push(mk(CMD_MAP, 1'b0, 0, 0, 32'd50, 0));
    push(mk(CMD_MAP, 1'b0, 0, 0, 32'd51, 0));
    push(mk(CMD_MAP, 1'b0, 0, 0, 32'hFFFF_FFFF, 0));
    push(mk(CMD_JUNC, 1'b0, 0, 0, 32'd40, 16'hFFFF));
    push(mk(CMD_JUNC, 1'b0, 0, 0, 32'd40, 16'd0));
    push(mk(CMD_JUNC, 1'b0, 0, 0, 32'd40, 16'd11));
    push(mk(CMD_JUNC, 1'b0, 0, 0, 32'hFFFF_FFFF, 16'hFFFF));
    push(mk(CMD_ADD, 1'b1, 32'd0, 32'd0, 0, 0));
    push(mk(CMD_MAP, 1'b0, 0, 0, 32'd1, 0));
    push(mk(CMD_CLEAR, 1'b1, '1, '1, '1, '1));
    for (int i = 0; i < MAXE + 1; i++)
      push(mk(CMD_ADD, 1'b1, 32'd1000 - i * 10, 32'd1004 - i * 10, 0, 0));
    push(mk(CMD_JUNC, 1'b0, 0, 0, 32'd1, 16'hFFFF));
    push(mk(CMD_MAP, 1'b0, 0, 0, 32'd320, 0));

    // Random phase: mostly well-formed transcripts, some raw noise
    while (cmd_q.size() < 425) begin
      if ($urandom_range(0, 4) == 0)
        push(mk(2'($urandom), 1'($urandom), $urandom, $urandom, $urandom,
                16'($urandom)));
      else random_transcript();
    end

    wait (pending_count == 0 && expected_q.size() == 0);
    repeat (MAXE * 4) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
